>>> rtl/core/csl_pkg.sv
package csl_pkg;

  // Width of the number accumulator; literals wrap modulo 2**VALUE_WIDTH.
  localparam int VALUE_WIDTH = 64;
  localparam int OUT_VALUE_W = 64;
  localparam int CHAR_W      = 8;
  localparam int KIND_W      = 5;

  // Character codes the lexer recognizes.
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LESS   = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_NUM   = 3'd1,
    M_IDENT = 3'd2,
    M_PLUS  = 3'd3,
    M_EQ    = 3'd4,
    M_HALT  = 3'd5
  } csl_mode_t;

  typedef enum logic [KIND_W-1:0] {
    K_INT    = 5'd0,
    K_ICHAR  = 5'd1,
    K_IEND   = 5'd2,
    K_PLUSEQ = 5'd3,
    K_INC    = 5'd4,
    K_PLUS   = 5'd5,
    K_MINUS  = 5'd6,
    K_STAR   = 5'd7,
    K_SLASH  = 5'd8,
    K_LPAR   = 5'd9,
    K_RPAR   = 5'd10,
    K_SEMI   = 5'd11,
    K_EQEQ   = 5'd12,
    K_EQ     = 5'd13,
    K_LBRACE = 5'd14,
    K_RBRACE = 5'd15,
    K_LESS   = 5'd16,
    K_COMMA  = 5'd17,
    K_ERROR  = 5'd18
  } csl_kind_t;

  typedef struct packed {
    csl_kind_t                      kind;
    logic signed [OUT_VALUE_W-1:0]  int_value;
    logic [CHAR_W-1:0]              ident_char;
    logic                           last;
  } csl_result_t;

  // Up to two results produced by one request, in order.
  typedef struct packed {
    csl_result_t res0;
    csl_result_t res1;
    logic [1:0]  count;
  } csl_step_res_t;

  typedef struct packed {
    logic      hit;
    csl_kind_t kind;
  } csl_single_t;

  function automatic csl_result_t make_res(csl_kind_t kind,
                                           logic signed [OUT_VALUE_W-1:0] val,
                                           logic [CHAR_W-1:0] ch);
    csl_result_t r;
    r.kind       = kind;
    r.int_value  = val;
    r.ident_char = ch;
    r.last       = 1'b0;
    return r;
  endfunction

  // Lookup for the operators and punctuation that stand alone.
  function automatic csl_single_t single_kind(logic [CHAR_W-1:0] c);
    csl_single_t s;
    s.hit  = 1'b1;
    s.kind = K_ERROR;
    case (c)
      CH_MINUS:  s.kind = K_MINUS;
      CH_STAR:   s.kind = K_STAR;
      CH_SLASH:  s.kind = K_SLASH;
      CH_LPAR:   s.kind = K_LPAR;
      CH_RPAR:   s.kind = K_RPAR;
      CH_SEMI:   s.kind = K_SEMI;
      CH_LBRACE: s.kind = K_LBRACE;
      CH_RBRACE: s.kind = K_RBRACE;
      CH_LESS:   s.kind = K_LESS;
      CH_COMMA:  s.kind = K_COMMA;
      default:   s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/csl_if.sv
// Character channel into the lexer.
interface csl_in_if;
  logic                        valid;
  logic                        ready;
  logic [csl_pkg::CHAR_W-1:0]  char_code;
  logic                        end_flag;

  modport source (output valid, output char_code, output end_flag, input ready);
  modport sink   (input valid, input char_code, input end_flag, output ready);
endinterface

// Token channel out of the lexer.
interface csl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [csl_pkg::KIND_W-1:0]            token_kind;
  logic signed [csl_pkg::OUT_VALUE_W-1:0] int_value;
  logic [csl_pkg::CHAR_W-1:0]            ident_char;
  logic                                  last_of_run;

  modport source (output valid, output token_kind, output int_value,
                  output ident_char, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_value,
                  input ident_char, input last_of_run, output ready);
endinterface

>>> rtl/core/csl_step.sv
module csl_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic [csl_pkg::CHAR_W-1:0]   char_code,
  input  logic                         end_flag,
  output csl_pkg::csl_step_res_t       step_res
);
  import csl_pkg::*;

  csl_mode_t              mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;

  logic                          is_digit, is_alpha, is_space;
  csl_single_t                   single;
  logic                          fresh;
  logic                          have_a, have_b;
  csl_result_t                   res_a, res_b;
  logic signed [OUT_VALUE_W-1:0] acc_ext;
  logic [VALUE_WIDTH-1:0]        acc_times_ten;

  // Character classes.
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_alpha = ((char_code >= CH_LC_A) && (char_code <= CH_LC_Z)) ||
                    ((char_code >= CH_UC_A) && (char_code <= CH_UC_Z));
  assign is_space = (char_code == CH_SPACE) ||
                    ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign single   = single_kind(char_code);

  // Literal value as presented on the output, and the next decimal digit step.
  assign acc_ext       = OUT_VALUE_W'($signed(acc_r));
  assign acc_times_ten = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(char_code[3:0]);

  // State register; it advances only when a request is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
    end else if (in_accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Next state and results. Result A closes, extends or completes a pending token,
  // result B comes from the new character itself.
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    fresh    = 1'b0;
    have_a   = 1'b0;
    have_b   = 1'b0;
    res_a    = make_res(K_INT, '0, '0);
    res_b    = make_res(K_INT, '0, '0);

    if (end_flag) begin
      case (mode_r)
        M_NUM: begin
          have_a = 1'b1;
          res_a  = make_res(K_INT, acc_ext, '0);
        end
        M_IDENT: begin
          have_a = 1'b1;
          res_a  = make_res(K_IEND, '0, '0);
        end
        M_PLUS: begin
          have_a = 1'b1;
          res_a  = make_res(K_PLUS, '0, '0);
        end
        M_EQ: begin
          have_a = 1'b1;
          res_a  = make_res(K_EQ, '0, '0);
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;
      acc_nxt  = '0;
    end else begin
      case (mode_r)
        M_IDLE: begin
          fresh = 1'b1;
        end
        M_NUM: begin
          if (is_digit) begin
            acc_nxt = acc_times_ten;
          end else begin
            have_a   = 1'b1;
            res_a    = make_res(K_INT, acc_ext, '0);
            mode_nxt = M_IDLE;
            acc_nxt  = '0;
            fresh    = 1'b1;
          end
        end
        M_IDENT: begin
          have_a = 1'b1;
          if (is_alpha || is_digit) begin
            res_a = make_res(K_ICHAR, '0, char_code);
          end else begin
            res_a    = make_res(K_IEND, '0, '0);
            mode_nxt = M_IDLE;
            fresh    = 1'b1;
          end
        end
        M_PLUS: begin
          have_a   = 1'b1;
          mode_nxt = M_IDLE;
          if (char_code == CH_EQUAL) begin
            res_a = make_res(K_PLUSEQ, '0, '0);
          end else if (char_code == CH_PLUS) begin
            res_a = make_res(K_INC, '0, '0);
          end else begin
            res_a = make_res(K_PLUS, '0, '0);
            fresh = 1'b1;
          end
        end
        M_EQ: begin
          have_a   = 1'b1;
          mode_nxt = M_IDLE;
          if (char_code == CH_EQUAL) begin
            res_a = make_res(K_EQEQ, '0, '0);
          end else begin
            res_a = make_res(K_EQ, '0, '0);
            fresh = 1'b1;
          end
        end
        default: begin
          // Halted, and any mode code without meaning, swallows characters.
          mode_nxt = M_HALT;
        end
      endcase

      if (fresh) begin
        if (is_space) begin
          // Whitespace is skipped.
        end else if (is_digit) begin
          mode_nxt = M_NUM;
          acc_nxt  = VALUE_WIDTH'(char_code[3:0]);
        end else if (is_alpha) begin
          mode_nxt = M_IDENT;
          have_b   = 1'b1;
          res_b    = make_res(K_ICHAR, '0, char_code);
        end else if (char_code == CH_PLUS) begin
          mode_nxt = M_PLUS;
        end else if (char_code == CH_EQUAL) begin
          mode_nxt = M_EQ;
        end else if (single.hit) begin
          have_b = 1'b1;
          res_b  = make_res(single.kind, '0, '0);
        end else begin
          have_b   = 1'b1;
          res_b    = make_res(K_ERROR, '0, '0);
          mode_nxt = M_HALT;
          acc_nxt  = '0;
        end
      end
    end
  end

  // Pack the results in order and mark the final one.
  always_comb begin
    step_res.res0  = res_b;
    step_res.res1  = res_b;
    step_res.count = 2'd0;
    if (have_a && have_b) begin
      step_res.res0      = res_a;
      step_res.res1      = res_b;
      step_res.res1.last = 1'b1;
      step_res.count     = 2'd2;
    end else if (have_a) begin
      step_res.res0      = res_a;
      step_res.res0.last = 1'b1;
      step_res.count     = 2'd1;
    end else if (have_b) begin
      step_res.res0      = res_b;
      step_res.res0.last = 1'b1;
      step_res.count     = 2'd1;
    end
  end

endmodule

>>> rtl/core/csl_obuf.sv
module csl_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   in_accept,
  input  csl_pkg::csl_step_res_t step_res,
  csl_out_if.source              out_ch
);
  import csl_pkg::*;

  csl_result_t slot0_r, slot0_nxt;
  csl_result_t slot1_r, slot1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  // A request is taken once the buffer is empty or about to be.
  assign pop       = out_ch.valid && out_ch.ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign in_accept = in_valid && in_ready;

  // Buffer update: load a whole request's results, or shift after a pop.
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (in_accept) begin
      slot0_nxt = step_res.res0;
      slot1_nxt = step_res.res1;
      cnt_nxt   = step_res.count;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // The head slot drives the token channel.
  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.token_kind  = slot0_r.kind;
  assign out_ch.int_value   = slot0_r.int_value;
  assign out_ch.ident_char  = slot0_r.ident_char;
  assign out_ch.last_of_run = slot0_r.last;

endmodule

>>> rtl/core/c_subset_lexer.sv
// Channel  Dir  Payload                                           Handshake
// in_ch    in   char_code[7:0], end_flag                          valid/ready
// out_ch   out  token_kind[4:0], int_value[63:0], ident_char[7:0], valid/ready
//               last_of_run
//
// One character is lexed in the cycle it is accepted; its tokens appear on
// out_ch from the next cycle. A character with zero or one token sustains one
// request per cycle while out_ch is ready; a character with two tokens holds
// the input until one token leaves the two-entry result buffer on out_ch.
// Reset (rst_n low, synchronous) returns the lexer to idle with an empty buffer.
// A stall on out_ch holds in_ch.ready low once a request's tokens are queued.
module c_subset_lexer (
  input  logic      clk,
  input  logic      rst_n,
  csl_in_if.sink    in_ch,
  csl_out_if.source out_ch
);
  import csl_pkg::*;

  csl_step_res_t step_res;
  logic          in_accept;

  // Lexer state and token decode.
  csl_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .char_code (in_ch.char_code),
    .end_flag  (in_ch.end_flag),
    .step_res  (step_res)
  );

  // Result buffer and output register.
  csl_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_accept (in_accept),
    .step_res  (step_res),
    .out_ch    (out_ch)
  );

endmodule
